// ----- rtl/tmc_pkg.sv -----
// Shared types and constants for the text-mode console writer.
`default_nettype none

package tmc_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 32;

  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 6;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 32;
  localparam int CELL_W     = 16;

  localparam logic [COLS_W-1:0] RESET_COLUMNS = 8'd80;
  localparam logic [ROWS_W-1:0] RESET_ROWS    = 6'd25;
  localparam logic [7:0]        RESET_ATTR    = 8'h0F;
  localparam logic [7:0]        NEWLINE_CHAR  = 8'h0A;
  localparam logic [7:0]        SPACE_CHAR    = 8'h20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_WRITE_CHAR = 3'd0,
    OP_MOVE_TO    = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_SET_ATTR   = 3'd3,
    OP_READ_CELL  = 3'd4
  } op_t;

  // remainder unit sizes
  localparam int MOD_DVD_W = 9;
  localparam int MOD_DVS_W = 8;
  localparam int MOD_CNT_W = $clog2(MOD_DVD_W);

  typedef struct packed {
    logic                 start;
    logic [MOD_DVD_W-1:0] dividend;
    logic [MOD_DVS_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                 done;
    logic [MOD_DVS_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/text_mode_console_writer.sv -----
// Text-mode console writer: sequencer, cursor state, cell RAM and remainder unit.
// Clear sweeps the screen one cell a cycle. One item at a time; the next item is
// taken as soon as the sequencer is idle, a finished result waits in the output
// register. Modulo steps go through the shared remainder unit. Synchronous
// active-low reset homes the cursor, sets attribute 0x0F and 80x25; cell
// contents are undefined until written.
`default_nettype none

module text_mode_console_writer #(
  parameter int MAX_COLUMNS = tmc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tmc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [tmc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [tmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // op, character, target_column, target_row, attribute (from bit 0)
  input  wire logic [tmc_pkg::IN_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // cursor_column, cursor_row, cell_character, cell_attribute (from bit 0)
  output logic      [tmc_pkg::OUT_W-1:0]      out_tdata
);

  import tmc_pkg::*;

  localparam int CW    = MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int PW    = RW + COLS_W;
  localparam int NW    = COLS_W + ROWS_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_COLMOD = 8'b0000_0010,
    S_ROWMOD = 8'b0000_0100,
    S_ADDR   = 8'b0000_1000,
    S_WRITE  = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [7:0]          ch_r, ch_nxt;
  logic [7:0]          tr_r, tr_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [7:0]          attr_r, attr_nxt;
  logic [COLS_W-1:0]   cols_r, cols_nxt;
  logic [ROWS_W-1:0]   rows_r, rows_nxt;
  logic [CW-1:0]       tcm_r, tcm_nxt;
  logic [RW-1:0]       trm_r, trm_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]       clr_last_r, clr_last_nxt;
  mod_req_t            mreq_r, mreq_nxt;
  mod_rsp_t            mrsp;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic [COLS_W-1:0]   eff_cols;
  logic [ROWS_W-1:0]   eff_rows;
  op_t                 in_op;
  logic [7:0]          in_ch, in_tc, in_tr, in_at;
  logic [CW-1:0]       sel_col;
  logic [RW-1:0]       sel_row;
  logic [PW-1:0]       prod;
  logic [PW:0]         addr_sum;
  logic [NW-1:0]       clr_n;
  logic [CW:0]         col_inc;
  logic [31:0]         col_ext, row_ext;
  logic [CELL_W-1:0]   rd_cell;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  assign in_op = op_t'(in_tdata[2:0]);
  assign in_ch = in_tdata[10:3];
  assign in_tc = in_tdata[18:11];
  assign in_tr = in_tdata[26:19];
  assign in_at = in_tdata[34:27];

  always_comb begin
    if (cols_r == '0) begin
      eff_cols = COLS_W'(1);
    end else if (int'(cols_r) > MAX_COLUMNS) begin
      eff_cols = COLS_W'(MAX_COLUMNS);
    end else begin
      eff_cols = cols_r;
    end
    if (rows_r == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_r;
    end
  end

  assign sel_col  = (op_r == OP_READ_CELL) ? tcm_r : col_r;
  assign sel_row  = (op_r == OP_READ_CELL) ? trm_r : row_r;
  assign prod     = PW'(sel_row) * PW'(eff_cols);
  assign addr_sum = (PW+1)'(prod) + (PW+1)'(sel_col);
  assign clr_n    = NW'(eff_cols) * NW'(eff_rows);
  assign col_inc  = (CW+1)'(col_r) + (CW+1)'(1);
  assign col_ext  = 32'(col_r);
  assign row_ext  = 32'(row_r);
  assign rd_cell  = (op_r == OP_READ_CELL) ? ram_rdata : '0;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    tr_nxt         = tr_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    attr_nxt       = attr_r;
    cols_nxt       = cols_r;
    rows_nxt       = rows_r;
    tcm_nxt        = tcm_r;
    trm_nxt        = trm_r;
    addr_nxt       = addr_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_last_nxt   = clr_last_r;
    mreq_nxt       = mreq_r;
    mreq_nxt.start = 1'b0;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = {attr_r, ch_r};

    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_COLUMNS: cols_nxt = cfg_wdata;
        REG_ROWS:    rows_nxt = cfg_wdata[ROWS_W-1:0];
        default:     cols_nxt = cols_r;
      endcase
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_op;
          ch_nxt = in_ch;
          tr_nxt = in_tr;
          unique case (in_op) inside
            OP_WRITE_CHAR: begin
              if (in_ch == NEWLINE_CHAR) begin
                col_nxt           = '0;
                mreq_nxt.start    = 1'b1;
                mreq_nxt.dividend = MOD_DVD_W'(row_r) + MOD_DVD_W'(1);
                mreq_nxt.divisor  = MOD_DVS_W'(eff_rows);
                state_nxt         = S_ROWMOD;
              end else begin
                state_nxt = S_ADDR;
              end
            end
            OP_MOVE_TO, OP_READ_CELL: begin
              mreq_nxt.start    = 1'b1;
              mreq_nxt.dividend = MOD_DVD_W'(in_tc);
              mreq_nxt.divisor  = eff_cols;
              state_nxt         = S_COLMOD;
            end
            OP_CLEAR: begin
              attr_nxt     = in_at;
              col_nxt      = '0;
              row_nxt      = '0;
              clr_cnt_nxt  = '0;
              clr_last_nxt = AW'(clr_n - NW'(1));
              state_nxt    = S_CLEAR;
            end
            OP_SET_ATTR: begin
              attr_nxt  = in_at;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_COLMOD: begin
        if (mrsp.done) begin
          if (op_r == OP_MOVE_TO) begin
            col_nxt = CW'(mrsp.rem);
          end else begin
            tcm_nxt = CW'(mrsp.rem);
          end
          mreq_nxt.start    = 1'b1;
          mreq_nxt.dividend = MOD_DVD_W'(tr_r);
          mreq_nxt.divisor  = MOD_DVS_W'(eff_rows);
          state_nxt         = S_ROWMOD;
        end
      end
      S_ROWMOD: begin
        if (mrsp.done) begin
          if (op_r == OP_READ_CELL) begin
            trm_nxt   = RW'(mrsp.rem);
            state_nxt = S_ADDR;
          end else begin
            row_nxt   = RW'(mrsp.rem);
            state_nxt = S_DONE;
          end
        end
      end
      S_ADDR: begin
        addr_nxt  = AW'(addr_sum);
        state_nxt = (op_r == OP_READ_CELL) ? S_READ : S_WRITE;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (col_inc >= (CW+1)'(eff_cols)) begin
          col_nxt           = '0;
          mreq_nxt.start    = 1'b1;
          mreq_nxt.dividend = MOD_DVD_W'(row_r) + MOD_DVD_W'(1);
          mreq_nxt.divisor  = MOD_DVS_W'(eff_rows);
          state_nxt         = S_ROWMOD;
        end else begin
          col_nxt   = col_inc[CW-1:0];
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = {attr_r, SPACE_CHAR};
        if (clr_cnt_r == clr_last_r) begin
          state_nxt = S_DONE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {(OUT_W-28)'(0), rd_cell[15:8], rd_cell[7:0],
                            row_ext[4:0], col_ext[6:0]};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      attr_r       <= RESET_ATTR;
      cols_r       <= RESET_COLUMNS;
      rows_r       <= RESET_ROWS;
      mreq_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      attr_r       <= attr_nxt;
      cols_r       <= cols_nxt;
      rows_r       <= rows_nxt;
      mreq_r       <= mreq_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    tr_r       <= tr_nxt;
    tcm_r      <= tcm_nxt;
    trm_r      <= trm_nxt;
    addr_r     <= addr_nxt;
    clr_cnt_r  <= clr_cnt_nxt;
    clr_last_r <= clr_last_nxt;
    out_data_r <= out_data_nxt;
  end

  tmc_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq_r),
    .rsp   (mrsp)
  );

  tmc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_mod_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == S_COLMOD || state_r == S_ROWMOD))
    else $error("remainder result arrived with no sequencer waiting");

  a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (clr_cnt_r <= clr_last_r))
    else $error("clear sweep ran past the last cell");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_CLEAR && state_r == S_DONE) |-> (col_r == '0 && row_r == '0))
    else $error("cursor not home after clear");

  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_tvalid_r) |=> (out_tvalid_r && state_r == S_IDLE))
    else $error("finished item did not reach the output register");

endmodule

`default_nettype wire

// ----- rtl/tmc_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tmc_mod.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module tmc_mod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tmc_pkg::mod_req_t req,
  output tmc_pkg::mod_rsp_t      rsp
);

  import tmc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_DVS_W-1:0] rem_r, rem_nxt;
  logic [MOD_DVD_W-1:0] dvd_r, dvd_nxt;
  logic [MOD_DVS_W-1:0] dvs_r, dvs_nxt;
  logic [MOD_DVS_W:0]   trial;
  logic [MOD_DVS_W:0]   diff;

  assign trial = {rem_r, dvd_r[MOD_DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[MOD_DVS_W-1:0];
      end else begin
        rem_nxt = trial[MOD_DVS_W-1:0];
      end
      dvd_nxt = {dvd_r[MOD_DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
      if (cnt_r == MOD_CNT_W'(MOD_DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ----- verif/tb_text_mode_console_writer.sv -----
`timescale 1ns / 1ps
// Testbench for text_mode_console_writer: directed and random console commands scored beat by beat.
module tb_text_mode_console_writer;
  import tmc_pkg::*;

  localparam int CELLS        = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int MAX_IDLE     = 17;
  localparam int RANDOM_ITEMS = 2000;
  localparam int SETTLE       = 50;
  localparam int LONG_HOLD    = 400;
  localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;

  typedef struct packed {
    logic [7:0] attribute;
    logic [7:0] target_row;
    logic [7:0] target_column;
    logic [7:0] character;
    logic [2:0] op;
  } console_cmd_t;

  typedef struct packed {
    logic [3:0] pad;
    logic [7:0] cell_attribute;
    logic [7:0] cell_character;
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
  } console_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;

  // console state mirrored in the bench
  logic [15:0]     screen_mem [CELLS];
  bit              screen_set [CELLS];
  int              cur_col;
  int              cur_row;
  logic [7:0]      cur_attr;
  logic [7:0]      cols_reg;
  logic [5:0]      rows_reg;
  console_report_t pending_reports[$];

  bit tx_steady;
  bit rx_steady;
  int rx_stall_left;
  int rx_hold_left;
  int cycle_count;
  int mismatches;
  int reports_checked;
  int geometries;
  int op_count[8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_mode_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic int used_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return int'(cols_reg);
  endfunction

  function automatic int used_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(rows_reg);
  endfunction

  function automatic int cell_addr(int col, int row);
    int a;
    a = row * used_cols() + col;
    return (a < CELLS) ? a : 0;
  endfunction

  function automatic int read_addr(console_cmd_t c);
    return cell_addr(c.target_column % used_cols(), c.target_row % used_rows());
  endfunction

  function automatic void advance_line();
    cur_col = 0;
    cur_row = (cur_row + 1) % used_rows();
  endfunction

  function automatic void console_reset();
    foreach (screen_set[i]) screen_set[i] = 1'b0;
    cur_col  = 0;
    cur_row  = 0;
    cur_attr = RESET_ATTR;
    cols_reg = RESET_COLUMNS;
    rows_reg = RESET_ROWS;
  endfunction

  // applies one command to the mirrored console, returns the report it yields
  function automatic console_report_t console_apply(console_cmd_t c);
    console_report_t rep;
    int a;
    int n;
    rep = '0;
    case (c.op)
      OP_WRITE_CHAR: begin
        if (c.character == NEWLINE_CHAR) begin
          advance_line();
        end else begin
          a = cell_addr(cur_col, cur_row);
          screen_mem[a] = {cur_attr, c.character};
          screen_set[a] = 1'b1;
          cur_col++;
          if (cur_col >= used_cols()) advance_line();
        end
      end
      OP_MOVE_TO: begin
        cur_col = c.target_column % used_cols();
        cur_row = c.target_row % used_rows();
      end
      OP_CLEAR: begin
        cur_attr = c.attribute;
        cur_col  = 0;
        cur_row  = 0;
        n = used_cols() * used_rows();
        for (int i = 0; i < n && i < CELLS; i++) begin
          screen_mem[i] = {cur_attr, SPACE_CHAR};
          screen_set[i] = 1'b1;
        end
      end
      OP_SET_ATTR: begin
        cur_attr = c.attribute;
      end
      OP_READ_CELL: begin
        a = read_addr(c);
        rep.cell_character = screen_mem[a][7:0];
        rep.cell_attribute = screen_mem[a][15:8];
      end
      default: ;
    endcase
    rep.cursor_column = cur_col[6:0];
    rep.cursor_row    = cur_row[4:0];
    return rep;
  endfunction

  function automatic console_cmd_t console_cmd(logic [2:0] op, logic [7:0] ch, logic [7:0] tc,
                                               logic [7:0] tr, logic [7:0] at);
    console_cmd_t c;
    c.op            = op;
    c.character     = ch;
    c.target_column = tc;
    c.target_row    = tr;
    c.attribute     = at;
    return c;
  endfunction

  function automatic console_cmd_t random_console_cmd();
    console_cmd_t c;
    int pick;
    c = console_cmd(OP_WRITE_CHAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      if ($urandom_range(0, 9) == 0) c.character = NEWLINE_CHAR;
    end else if (pick < 52) begin
      c.op = OP_MOVE_TO;
    end else if (pick < 55) begin
      c.op = OP_CLEAR;
      // big screens clear slowly, keep those rare
      if (used_cols() * used_rows() > 256 && $urandom_range(0, 3) != 0) c.op = OP_SET_ATTR;
    end else if (pick < 65) begin
      c.op = OP_SET_ATTR;
    end else if (pick < 95) begin
      c.op = OP_READ_CELL;
      if (!screen_set[read_addr(c)]) c.op = OP_MOVE_TO;
    end else begin
      c.op = FIRST_UNUSED_OP + 3'($urandom_range(0, 2));
    end
    return c;
  endfunction

  task automatic send_cmd(input console_cmd_t c);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - $bits(console_cmd_t)){1'b0}}, c};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pending_reports.push_back(console_apply(c));
    op_count[c.op]++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    if (idx == REG_COLUMNS) cols_reg = value;
    else rows_reg = value[5:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
    wait_drained();
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    geometries++;
  endtask

  task automatic note_mismatch(input string field, input int expv, input int actv);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, expv, actv);
  endtask

  // receiver: per-beat stall plus an optional long hold
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    console_report_t got;
    console_report_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = out_tdata;
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected beat", 0, int'(got));
      end else begin
        want = pending_reports.pop_front();
        if (got.cursor_column !== want.cursor_column)
          note_mismatch("cursor_column", want.cursor_column, got.cursor_column);
        if (got.cursor_row !== want.cursor_row)
          note_mismatch("cursor_row", want.cursor_row, got.cursor_row);
        if (got.cell_character !== want.cell_character)
          note_mismatch("cell_character", want.cell_character, got.cell_character);
        if (got.cell_attribute !== want.cell_attribute)
          note_mismatch("cell_attribute", want.cell_attribute, got.cell_attribute);
        if (got.pad !== want.pad)
          note_mismatch("padding", want.pad, got.pad);
      end
      reports_checked++;
      rx_stall_left = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed_ops();
    send_cmd(console_cmd(OP_SET_ATTR, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_MOVE_TO, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    for (int k = int'(FIRST_UNUSED_OP); k < 8; k++)
      send_cmd(console_cmd(3'(k), 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(console_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_SET_ATTR, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, 8'h00, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, NEWLINE_CHAR - 8'd1, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, NEWLINE_CHAR + 8'd1, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'd0, 8'd0, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'd1, 8'd0, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'd3, 8'd0, 8'h00));
    // last cell of the screen: write wraps both column and row
    send_cmd(console_cmd(OP_MOVE_TO, 8'h00, 8'd79, 8'd24, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, 8'h41, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'd79, 8'd24, 8'h00));
    send_cmd(console_cmd(OP_MOVE_TO, 8'h00, 8'd0, 8'd24, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'hFF, 8'hFF, 8'h00));
  endtask

  task automatic test_geometry_extremes();
    // zero registers act as a 1x1 screen
    set_geometry(8'd0, 8'd0);
    send_cmd(console_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h5A));
    send_cmd(console_cmd(OP_WRITE_CHAR, 8'h78, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'hFF, 8'hFF, 8'h00));
    send_cmd(console_cmd(OP_MOVE_TO, 8'h00, 8'hFF, 8'hFF, 8'h00));
    // oversize registers clamp to the full store
    set_geometry(8'hFF, 8'hFF);
    send_cmd(console_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'hA5));
    send_cmd(console_cmd(OP_MOVE_TO, 8'h00, 8'hFF, 8'hFF, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, 8'h7E, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'd127, 8'd31, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'd200, 8'd40, 8'h00));
    set_geometry(8'(MAX_COLUMNS_DEF), 8'(MAX_ROWS_DEF));
    send_cmd(console_cmd(OP_MOVE_TO, 8'h00, 8'd100, 8'd20, 8'h00));
    // shrink under the cursor, then write from outside the screen
    set_geometry(8'd10, 8'd4);
    send_cmd(console_cmd(OP_WRITE_CHAR, 8'h51, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_WRITE_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 8'hFF, 8'hFF, 8'h00));
    set_geometry(RESET_COLUMNS, 8'(RESET_ROWS));
    send_cmd(console_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, RESET_ATTR));
  endtask

  task automatic test_backpressure();
    set_geometry(8'd12, 8'd6);
    send_cmd(console_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h1E));
    wait_drained();
    tx_steady = 1'b1;
    rx_hold_left = LONG_HOLD;
    repeat (40) send_cmd(random_console_cmd());
    tx_steady = 1'b0;
    release_input();
    wait_drained();
    repeat (20) send_cmd(random_console_cmd());
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        set_geometry(8'($urandom_range(1, 16)), 8'($urandom_range(1, 8)));
      else if (pick < 9)
        set_geometry(8'($urandom_range(1, MAX_COLUMNS_DEF)), 8'($urandom_range(1, MAX_ROWS_DEF)));
      else
        set_geometry(8'($urandom), 8'($urandom));
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_cmd(console_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        sent++;
      end
      len = $urandom_range(40, 160);
      repeat (len) send_cmd(random_console_cmd());
      sent += len;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = REG_COLUMNS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    console_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_geometry_extremes();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    release_input();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("commands: %0d writes, %0d moves, %0d clears, %0d attribute sets, %0d reads",
             op_count[OP_WRITE_CHAR], op_count[OP_MOVE_TO], op_count[OP_CLEAR],
             op_count[OP_SET_ATTR], op_count[OP_READ_CELL]);
    $display("%0d unused-op beats, %0d results scored over %0d screen sizes, %0d mismatches",
             op_count[5] + op_count[6] + op_count[7], reports_checked, geometries, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
